>>> hdl/lpmd_pkg.sv
// Package for the length-prefixed message deframer.
// Holds the item types and header constants; used by every module in hdl/.
`default_nettype none

package lpmd_pkg;

  // Header is one type byte followed by a four-byte big-endian length
  localparam int unsigned HeaderLen = 5;
  localparam int unsigned HdrCntW   = 3;
  localparam int unsigned LenW      = 32;

  localparam logic [HdrCntW-1:0] HDR_TYPE = 3'd0;
  localparam logic [HdrCntW-1:0] HDR_DONE = 3'(HeaderLen);

  // Input item kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] message_type;
    logic [7:0] payload_byte;
    logic       empty_message;
    logic       last_of_message;
  } out_item_t;

  // Result handed from the parser to the output buffer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } lpmd_res_t;

endpackage

`default_nettype wire

>>> hdl/lpmd_parser.sv
// Header/payload parser for the deframer: holds the framing state and forms
// at most one result per accepted byte. Depends on lpmd_pkg.
`default_nettype none

module lpmd_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire lpmd_pkg::in_item_t        in_item,
  output lpmd_pkg::lpmd_res_t            res,
  output logic [lpmd_pkg::HdrCntW-1:0]   header_count
);
  import lpmd_pkg::*;

  logic [HdrCntW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [LenW-1:0]    len_r, len_nxt;
  logic [LenW-1:0]    rem_r, rem_nxt;

  logic               in_payload;
  logic [HdrCntW-1:0] eff_cnt;
  logic [HdrCntW-1:0] cnt_inc;
  logic [LenW-1:0]    eff_len;
  logic [LenW-1:0]    len_shifted;
  logic [LenW-1:0]    rem_dec;

  // Payload phase only while bytes are still due; otherwise start a header
  always_comb begin
    in_payload  = (hdr_cnt_r >= HDR_DONE) && (rem_r != '0);
    eff_cnt     = (hdr_cnt_r >= HDR_DONE) ? HDR_TYPE : hdr_cnt_r;
    eff_len     = (hdr_cnt_r >= HDR_DONE) ? '0 : len_r;
    cnt_inc     = eff_cnt + HdrCntW'(1);
    len_shifted = {eff_len[LenW-9:0], in_item.data_byte};
    rem_dec     = rem_r - LenW'(1);
  end

  // Next framing state and result for the accepted byte
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    res         = '0;
    res.item.message_type = type_r;
    if (accept) begin
      if (in_item.kind == KIND_CLEAR) begin
        hdr_cnt_nxt = HDR_TYPE;
        type_nxt    = '0;
        len_nxt     = '0;
        rem_nxt     = '0;
      end else if (!in_payload) begin
        if (eff_cnt == HDR_TYPE) begin
          type_nxt    = in_item.data_byte;
          len_nxt     = '0;
          hdr_cnt_nxt = HdrCntW'(1);
        end else begin
          len_nxt     = len_shifted;
          hdr_cnt_nxt = cnt_inc;
          if (cnt_inc == HDR_DONE) begin
            if (len_shifted == '0) begin
              res.valid                = 1'b1;
              res.item.empty_message   = 1'b1;
              res.item.last_of_message = 1'b1;
              hdr_cnt_nxt              = HDR_TYPE;
            end else begin
              rem_nxt = len_shifted;
            end
          end
        end
      end else begin
        rem_nxt                  = rem_dec;
        res.valid                = 1'b1;
        res.item.payload_byte    = in_item.data_byte;
        res.item.last_of_message = (rem_dec == '0);
        if (rem_dec == '0) begin
          hdr_cnt_nxt = HDR_TYPE;
          len_nxt     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= HDR_TYPE;
      type_r    <= '0;
      len_r     <= '0;
      rem_r     <= '0;
    end else begin
      hdr_cnt_r <= hdr_cnt_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      rem_r     <= rem_nxt;
    end
  end

  assign header_count = hdr_cnt_r;

endmodule

`default_nettype wire

>>> hdl/lpmd_outbuf.sv
// Output register with a skid stage for the deframer's result channel.
// Lets the parser take a byte while a result waits. Depends on lpmd_pkg.
`default_nettype none

module lpmd_outbuf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lpmd_pkg::lpmd_res_t  res,
  output logic                      full,
  output logic                      out_valid,
  output lpmd_pkg::out_item_t       out_item,
  input  wire logic                 out_stall
);
  import lpmd_pkg::*;

  logic      main_vld_r, main_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  // Refill the output register from the skid stage first, then from the parser
  always_comb begin
    pop          = main_vld_r && !out_stall;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (res.valid) begin
      if (!main_vld_r || pop) begin
        main_nxt     = res.item;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res.item;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_item  = main_r;

endmodule

`default_nettype wire

>>> hdl/length_prefixed_message_deframer.sv
// Length-prefixed message deframer: one stream byte per item, results tagged
// with the message type. Results are registered in the output buffer before
// out_valid. Throughput 1 byte per cycle while in_stall is low; the framing
// state and length counter update in the accept cycle. in_stall rises only
// when the skid stage is occupied. Synchronous active-low reset returns the
// parser to the start of a header and empties the output buffer.
`default_nettype none

module length_prefixed_message_deframer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lpmd_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lpmd_pkg::out_item_t    out_item
);
  import lpmd_pkg::*;

  logic               accept;
  lpmd_res_t          res;
  logic               buf_full;
  logic [HdrCntW-1:0] header_count;

  // Take a byte whenever the skid stage is free
  assign accept   = in_valid && !buf_full;
  assign in_stall = buf_full;

  lpmd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_item      (in_item),
    .res          (res),
    .header_count (header_count)
  );

  lpmd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  // A clear item sends the parser back to the type byte
  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == KIND_CLEAR) |=> (header_count == HDR_TYPE))
    else $error("header count not cleared after clear item");

  // Header count never passes the header length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_count <= HDR_DONE)
    else $error("header count out of range");

  // The skid stage only fills behind a held output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid stage full with empty output register");

  // An empty-message result is always the last of its message
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.item.empty_message) |-> res.item.last_of_message)
    else $error("empty message result not marked last");

endmodule

`default_nettype wire
